/* sv/frustum_sphere_cull_test_core_macros.svh */
// Assertion macros for the frustum sphere cull test core.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef FRUSTUM_SPHERE_CULL_TEST_CORE_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_TEST_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define FSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fsc assertion failed");
// Checked on every edge, reset included.
`define FSC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fsc assertion failed");
`else
`define FSC_ASSERT(label, clk, rst, prop)
`define FSC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* sv/fsc_pkg.sv */
// Shared types and constants for the frustum sphere cull test core.
// No dependencies.
package fsc_pkg;

  // Q16.16 fixed point: d and radius are scaled by this shift.
  localparam int FRAC_BITS = 16;
  // Width of the plane index field.
  localparam int PIDX_W = 3;
  // Compare width for the index decode; covers up to 32 planes.
  localparam int IDX_CMP_W = 5;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [PIDX_W-1:0] idx;
  } store_wr_t;

endpackage

/* sv/frustum_sphere_cull_test_core.sv */
// Top level of the frustum sphere cull test core: handshake, pipeline, result.
// Depends on fsc_pkg, fsc_plane_store, fsc_dist_lane and the macros header.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | in_valid/in_ready  | cmd, plane_index, coef_a..d, point_x..z,
//            |                    | radius
//   output   | out_valid/out_ready| inside_res (one per test transaction)
//
// One transaction per cycle in steady state while the result is not stalled.
// A test passes the input register, the product register (the 32x32
// multipliers of every plane lane), then the result register fed by the exact
// sum and sign check. A load writes its plane when it leaves the input
// register, so loads and tests act on the planes in arrival order. Loads give
// no result. Synchronous reset clears the planes to zero and empties the
// pipeline. A stalled result holds the output register; stages behind it keep
// filling until every stage is occupied.

`include "frustum_sphere_cull_test_core_macros.svh"

module frustum_sphere_cull_test_core #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [fsc_pkg::PIDX_W-1:0]     plane_index,
  input  logic signed [COORD_WIDTH-1:0]  coef_a,
  input  logic signed [COORD_WIDTH-1:0]  coef_b,
  input  logic signed [COORD_WIDTH-1:0]  coef_c,
  input  logic signed [COORD_WIDTH-1:0]  coef_d,
  input  logic signed [COORD_WIDTH-1:0]  point_x,
  input  logic signed [COORD_WIDTH-1:0]  point_y,
  input  logic signed [COORD_WIDTH-1:0]  point_z,
  input  logic        [COORD_WIDTH-2:0]  radius,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           inside_res
);
  import fsc_pkg::*;

  // input register (stage 0)
  logic                          s0_valid;
  cmd_t                          s0_cmd;
  logic [PIDX_W-1:0]             s0_idx;
  logic signed [COORD_WIDTH-1:0] s0_a;
  logic signed [COORD_WIDTH-1:0] s0_b;
  logic signed [COORD_WIDTH-1:0] s0_c;
  logic signed [COORD_WIDTH-1:0] s0_d;
  logic signed [COORD_WIDTH-1:0] s0_x;
  logic signed [COORD_WIDTH-1:0] s0_y;
  logic signed [COORD_WIDTH-1:0] s0_z;
  logic        [COORD_WIDTH-2:0] s0_r;

  // product register (stage 1) holds a test only
  logic s1_valid;

  logic s1_go;
  logic s1_free;
  logic s0_go;
  logic in_acc;

  store_wr_t store_wr;

  logic signed [COORD_WIDTH-1:0] pl_a [NUM_PLANES];
  logic signed [COORD_WIDTH-1:0] pl_b [NUM_PLANES];
  logic signed [COORD_WIDTH-1:0] pl_c [NUM_PLANES];
  logic signed [COORD_WIDTH-1:0] pl_d [NUM_PLANES];

  logic [NUM_PLANES-1:0] below;

  // Stage advance. A load leaves stage 0 without needing stage 1.
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign s1_free  = !s1_valid || s1_go;
  assign s0_go    = s0_valid && ((s0_cmd == CMD_LOAD) || s1_free);
  assign in_ready = !s0_valid || s0_go;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_cmd <= cmd_t'(cmd);
      s0_idx <= plane_index;
      s0_a   <= coef_a;
      s0_b   <= coef_b;
      s0_c   <= coef_c;
      s0_d   <= coef_d;
      s0_x   <= point_x;
      s0_y   <= point_y;
      s0_z   <= point_z;
      s0_r   <= radius;
    end
  end

  // Out-of-range indexes are filtered in the store decode.
  assign store_wr.we  = s0_go && (s0_cmd == CMD_LOAD);
  assign store_wr.idx = s0_idx;

  fsc_plane_store #(
    .NUM_PLANES  (NUM_PLANES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (store_wr),
    .wr_a   (s0_a),
    .wr_b   (s0_b),
    .wr_c   (s0_c),
    .wr_d   (s0_d),
    .coef_a (pl_a),
    .coef_b (pl_b),
    .coef_c (pl_c),
    .coef_d (pl_d)
  );

  // One lane per plane; all product registers load when stage 1 frees up.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fsc_dist_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk    (clk),
      .en     (s1_free),
      .a      (pl_a[p]),
      .b      (pl_b[p]),
      .c      (pl_c[p]),
      .d      (pl_d[p]),
      .x      (s0_x),
      .y      (s0_y),
      .z      (s0_z),
      .radius (s0_r),
      .below  (below[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s0_go && (s0_cmd == CMD_TEST);
    end
  end

  // Result register: inside unless some plane puts the sphere fully behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      inside_res <= ~(|below);
    end
  end

  // Input stalls only when every stage is full behind a blocked result.
  `FSC_ASSERT(a_stall_full, clk, rst, !in_ready |-> s1_valid && out_valid && !out_ready)
  // A test held in stage 1 behind a stalled result is not dropped.
  `FSC_ASSERT(a_s1_hold, clk, rst, s1_valid && out_valid && !out_ready |=> s1_valid)
  // Only a load leaving stage 0 writes the planes.
  `FSC_ASSERT(a_store_we, clk, rst, store_wr.we |-> s0_valid && s0_cmd == CMD_LOAD)
  // Reset empties every stage.
  `FSC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !s0_valid && !s1_valid && !out_valid)

endmodule

/* sv/fsc_plane_store.sv */
// Plane coefficient registers, one entry of a, b, c, d per plane.
// Depends on fsc_pkg.
module fsc_plane_store #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fsc_pkg::store_wr_t            wr,
  input  logic signed [COORD_WIDTH-1:0] wr_a,
  input  logic signed [COORD_WIDTH-1:0] wr_b,
  input  logic signed [COORD_WIDTH-1:0] wr_c,
  input  logic signed [COORD_WIDTH-1:0] wr_d,
  output logic signed [COORD_WIDTH-1:0] coef_a [NUM_PLANES],
  output logic signed [COORD_WIDTH-1:0] coef_b [NUM_PLANES],
  output logic signed [COORD_WIDTH-1:0] coef_c [NUM_PLANES],
  output logic signed [COORD_WIDTH-1:0] coef_d [NUM_PLANES]
);
  import fsc_pkg::*;

  logic [IDX_CMP_W-1:0] idx_ext;

  assign idx_ext = IDX_CMP_W'(wr.idx);

  // Indexes at or above NUM_PLANES match no entry and are dropped.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (rst) begin
        coef_a[i] <= '0;
        coef_b[i] <= '0;
        coef_c[i] <= '0;
        coef_d[i] <= '0;
      end else if (wr.we && (idx_ext == IDX_CMP_W'(i))) begin
        coef_a[i] <= wr_a;
        coef_b[i] <= wr_b;
        coef_c[i] <= wr_c;
        coef_d[i] <= wr_d;
      end
    end
  end

endmodule

/* sv/fsc_dist_lane.sv */
// One plane's distance lane: registered products, then exact sum and sign.
// Depends on fsc_pkg.
module fsc_dist_lane #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  input  logic signed [COORD_WIDTH-1:0] c,
  input  logic signed [COORD_WIDTH-1:0] d,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  input  logic        [COORD_WIDTH-2:0] radius,
  output logic                          below
);
  import fsc_pkg::*;

  localparam int PW  = 2 * COORD_WIDTH;  // product width
  localparam int DRW = PW + 1;           // (d + r) << 16
  localparam int SW  = PW + 3;           // full sum, never overflows

  logic signed [PW-1:0]  pa;
  logic signed [PW-1:0]  pb;
  logic signed [PW-1:0]  pc;
  logic signed [DRW-1:0] dr;
  logic signed [DRW-1:0] d_ext;
  logic signed [DRW-1:0] r_ext;
  logic signed [SW-1:0]  sum;

  assign d_ext = DRW'(d);
  assign r_ext = DRW'($signed({1'b0, radius}));

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= a * x;
      pb <= b * y;
      pc <= c * z;
      dr <= (d_ext + r_ext) <<< FRAC_BITS;
    end
  end

  // distance + radius, all in Q32.32; negative means outside this plane
  assign sum   = SW'(pa) + SW'(pb) + SW'(pc) + SW'(dr);
  assign below = sum[SW-1];

endmodule

/* tb/fsc_cull_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the frustum sphere cull test core: mirrors the plane store,
// predicts inside_res per test transaction and compares. Depends on fsc_pkg.
module fsc_cull_checker #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          cmd,
  input  logic [fsc_pkg::PIDX_W-1:0]    plane_index,
  input  logic signed [COORD_WIDTH-1:0] coef_a,
  input  logic signed [COORD_WIDTH-1:0] coef_b,
  input  logic signed [COORD_WIDTH-1:0] coef_c,
  input  logic signed [COORD_WIDTH-1:0] coef_d,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic        [COORD_WIDTH-2:0] radius,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          inside_res,
  output int unsigned                   fail_count,
  output int unsigned                   outstanding
);

  typedef struct {
    logic signed [COORD_WIDTH-1:0] a, b, c, d;
  } plane_t;

  plane_t      planes [NUM_PLANES];
  bit          expected_inside [$];
  int unsigned mismatches = 0;

  // Exact distance test against every plane: a*x + b*y + c*z + d + r >= 0,
  // all terms in Q32.32 on a 128-bit signed accumulator.
  function automatic bit sphere_in_frustum(
    input logic signed [COORD_WIDTH-1:0] x,
    input logic signed [COORD_WIDTH-1:0] y,
    input logic signed [COORD_WIDTH-1:0] z,
    input logic        [COORD_WIDTH-2:0] r
  );
    logic signed [127:0] px, py, pz, pa, pb, pc, pd, rw, acc;
    bit ok;
    ok = 1'b1;
    px = x;
    py = y;
    pz = z;
    rw = '0;
    rw[COORD_WIDTH-2:0] = r;
    rw = rw <<< fsc_pkg::FRAC_BITS;
    for (int i = 0; i < NUM_PLANES; i++) begin
      pa  = planes[i].a;
      pb  = planes[i].b;
      pc  = planes[i].c;
      pd  = planes[i].d;
      acc = pa * px + pb * py + pc * pz + (pd <<< fsc_pkg::FRAC_BITS) + rw;
      if (acc < 0) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] checker: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) planes[i] = '{default: '0};
      expected_inside.delete();
    end else begin
      // result side first: it can only belong to an earlier transaction
      if (out_valid && out_ready) begin
        if (expected_inside.size() == 0) begin
          flag_error($sformatf("result %0b with nothing expected", inside_res));
        end else begin
          want = expected_inside.pop_front();
          if (inside_res !== want)
            flag_error($sformatf("inside_res expected %0b got %0b", want, inside_res));
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == fsc_pkg::CMD_TEST) begin
          expected_inside.push_back(sphere_in_frustum(point_x, point_y, point_z, radius));
        end else if (plane_index < NUM_PLANES) begin
          planes[plane_index].a = coef_a;
          planes[plane_index].b = coef_b;
          planes[plane_index].c = coef_c;
          planes[plane_index].d = coef_d;
        end
      end
    end
    outstanding <= expected_inside.size();
    fail_count  <= mismatches;
  end

endmodule

/* tb/tb_frustum_sphere_cull_test_core.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for frustum_sphere_cull_test_core.
// Depends on fsc_pkg, the core and fsc_cull_checker.
module tb_frustum_sphere_cull_test_core;

  import fsc_pkg::*;

  localparam int W          = 32;
  localparam int N_RANDOM   = 1800;
  localparam int CYCLE_CAP  = 400000;

  localparam logic signed [W-1:0] ONE  = 32'sh0001_0000;   // 1.0 in Q16.16
  localparam logic signed [W-1:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [W-1:0] CMIN = 32'sh8000_0000;
  localparam logic        [W-2:0] RMAX = 31'h7fff_ffff;

  // One input transaction as the sender sees it.
  typedef struct {
    cmd_t                op;
    logic [PIDX_W-1:0]   idx;
    logic signed [W-1:0] a, b, c, d;
    logic signed [W-1:0] x, y, z;
    logic        [W-2:0] r;
  } cull_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = CMD_LOAD;
  logic [PIDX_W-1:0]   plane_index = '0;
  logic signed [W-1:0] coef_a = '0, coef_b = '0, coef_c = '0, coef_d = '0;
  logic signed [W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic        [W-2:0] radius = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                inside_res;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycles = 0;

  // calm flags give stretches with no idling on either side
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frustum_sphere_cull_test_core #(
    .NUM_PLANES  (6),
    .COORD_WIDTH (W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .plane_index (plane_index),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .coef_c      (coef_c),
    .coef_d      (coef_d),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .radius      (radius),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .inside_res  (inside_res)
  );

  fsc_cull_checker #(
    .NUM_PLANES  (6),
    .COORD_WIDTH (W)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .plane_index (plane_index),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .coef_c      (coef_c),
    .coef_d      (coef_d),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .radius      (radius),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .inside_res  (inside_res),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Watchdog: bounds the run well above the slowest legal schedule.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("tb_frustum_sphere_cull_test_core failed");
      $finish;
    end
  end

  // Result side: per result, optionally hold ready low first, then wait for valid.
  initial begin
    int unsigned gap;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic cull_req_t load_req(input logic [PIDX_W-1:0] idx,
                                         input logic signed [W-1:0] a, b, c, d);
    cull_req_t t;
    t = '{op: CMD_LOAD, idx: idx, a: a, b: b, c: c, d: d,
          x: '0, y: '0, z: '0, r: '0};
    return t;
  endfunction

  function automatic cull_req_t test_req(input logic signed [W-1:0] x, y, z,
                                         input logic [W-2:0] r);
    cull_req_t t;
    t = '{op: CMD_TEST, idx: '0, a: '0, b: '0, c: '0, d: '0,
          x: x, y: y, z: z, r: r};
    return t;
  endfunction

  // Mix of full-range, small, fractional and extreme coordinates.
  function automatic logic signed [W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 8 * 65536) - 4 * 65536;
      7: begin
        case ($urandom_range(0, 3))
          0:       return CMIN;
          1:       return CMAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      8:       return $urandom_range(0, 510) - 255;
      default: return $urandom_range(0, 1) ? ONE : -ONE;
    endcase
  endfunction

  function automatic logic [W-2:0] rand_radius();
    case ($urandom_range(0, 8))
      0, 1, 2: return (W-1)'($urandom);
      3, 4:    return (W-1)'($urandom_range(0, 4 * 65536));
      5:       return '0;
      6:       return RMAX;
      default: return (W-1)'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: optionally idle first, then hold the transaction until accepted.
  task automatic send_req(input cull_req_t t);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= t.op;
    plane_index <= t.idx;
    coef_a      <= t.a;
    coef_b      <= t.b;
    coef_c      <= t.c;
    coef_d      <= t.d;
    point_x     <= t.x;
    point_y     <= t.y;
    point_z     <= t.z;
    radius      <= t.r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned run;
    cull_req_t   t;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed ----
    // cleared planes: every point is inside
    send_req(test_req(0, 0, 0, '0));
    send_req(test_req(CMAX, CMIN, CMAX, RMAX));
    // loads past the last plane must leave the store alone
    send_req(load_req(3'd6, -ONE, -ONE, -ONE, -ONE));
    send_req(load_req(3'd7, CMIN, CMIN, CMIN, CMIN));
    send_req(test_req(CMIN, CMAX, CMIN, '0));
    // near plane x >= 0: flush point, just outside, exactly at the bound
    send_req(load_req(3'd0, ONE, 0, 0, 0));
    send_req(test_req(0, CMAX, CMIN, '0));
    send_req(test_req(-1, 0, 0, '0));
    send_req(test_req(-1, 0, 0, 31'd1));
    send_req(test_req(-2, 0, 0, 31'd1));
    // extreme coefficients with extreme points, no saturation anywhere
    send_req(load_req(3'd1, CMIN, CMIN, CMIN, CMIN));
    send_req(test_req(CMIN, CMIN, CMIN, RMAX));
    send_req(load_req(3'd0, 0, 0, 0, 0));
    send_req(test_req(CMIN, CMIN, CMIN, '0));
    send_req(test_req(CMAX, CMAX, CMAX, RMAX));
    send_req(load_req(3'd2, CMAX, CMAX, CMAX, CMAX));
    send_req(test_req(CMAX, CMIN, CMAX, RMAX));
    send_req(load_req(3'd1, 0, 0, 0, 0));
    send_req(load_req(3'd2, 0, 0, 0, 0));
    // largest d against largest radius: sum lands exactly on zero
    send_req(load_req(3'd5, 0, 0, 0, -CMAX));
    send_req(test_req(0, 0, 0, RMAX));
    send_req(test_req(0, 0, 0, RMAX - 31'd1));
    send_req(load_req(3'd5, 0, 0, 0, 0));
    drain();

    // ---- random ----
    // Mostly runs of tests against small frustums built from six loads,
    // plus single full-range loads to any index as noise.
    sent = 0;
    while (sent < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int p = 0; p < 6; p++) begin
            if ($urandom_range(0, 4) == 0)
              t = load_req(PIDX_W'(p), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord());
            else
              t = load_req(PIDX_W'(p), $urandom_range(0, 8 * 65536) - 4 * 65536,
                           $urandom_range(0, 8 * 65536) - 4 * 65536,
                           $urandom_range(0, 8 * 65536) - 4 * 65536,
                           $urandom_range(0, 16 * 65536));
            send_req(t);
            sent++;
          end
        end
        2: begin
          t = load_req(PIDX_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                       $urandom);
          send_req(t);
          if (t.idx < 6) sent++;
        end
        default: begin
          run = $urandom_range(1, 8);
          repeat (run) begin
            send_req(test_req(rand_coord(), rand_coord(), rand_coord(), rand_radius()));
            sent++;
          end
        end
      endcase
      if (sent >= N_RANDOM / 2 && sent < N_RANDOM / 2 + 8) drain();
    end

    // ---- wind down ----
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_frustum_sphere_cull_test_core passed");
    end else begin
      $display("tb_frustum_sphere_cull_test_core failed");
    end
    $finish;
  end

endmodule

/* frustum_sphere_cull_test_core.f */
+incdir+sv
sv/fsc_pkg.sv
sv/fsc_plane_store.sv
sv/fsc_dist_lane.sv
sv/frustum_sphere_cull_test_core.sv
tb/fsc_cull_checker.sv
tb/tb_frustum_sphere_cull_test_core.sv
